/* src/tcd_pkg.sv */
`default_nettype none
package tcd_pkg;

  // Capture store geometry and timestamp width
  localparam int CAPTURE_DEPTH = 256;
  localparam int TIME_BITS     = 32;

  localparam int ADDR_W  = $clog2(CAPTURE_DEPTH);
  localparam int CIDX_W  = $clog2(CAPTURE_DEPTH + 1);
  localparam int CNT_W   = (CIDX_W > 8) ? CIDX_W : 8;
  localparam int ENTRY_W = 8 + TIME_BITS;

  localparam logic [7:0] TARGET_RST = 8'd255;

  // Frame delimiters
  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // Input beat kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_GO   = 1'b1;

  // Byte positions inside one frame
  localparam logic [2:0] BP_HEAD = 3'd0;
  localparam logic [2:0] BP_PINS = 3'd1;
  localparam logic [2:0] BP_T3   = 3'd2;
  localparam logic [2:0] BP_T2   = 3'd3;
  localparam logic [2:0] BP_T1   = 3'd4;
  localparam logic [2:0] BP_T0   = 3'd5;
  localparam logic [2:0] BP_TAIL = 3'd6;

  typedef enum logic [3:0] {
    PH_MONITOR  = 4'b0001,
    PH_SAMPLING = 4'b0010,
    PH_SENDING  = 4'b0100,
    PH_WAITING  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } ctl_t;

  // Pick one byte of a frame from the stored entry
  function automatic logic [7:0] frame_byte(input logic [2:0] pos,
                                            input logic [ENTRY_W-1:0] entry);
    logic [31:0] t32;
    logic [7:0]  b;
    t32 = 32'(entry[TIME_BITS-1:0]);
    case (pos)
      BP_HEAD: b = CHAR_AT;
      BP_PINS: b = entry[ENTRY_W-1 -: 8];
      BP_T3:   b = t32[31:24];
      BP_T2:   b = t32[23:16];
      BP_T1:   b = t32[15:8];
      BP_T0:   b = t32[7:0];
      BP_TAIL: b = CHAR_SEMI;
      default: b = CHAR_SEMI;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* src/tcd_ram.sv */
`default_nettype none
module tcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/transition_capture_dump_core.sv */
`default_nettype none
// Transition capture engine with frame dump.
// Input stream: each beat is either a tick carrying the 8 probed pins
// (in_tuser = 0) or a go byte carrying a new capture target (in_tuser = 1).
// In monitor phase a tick whose pins differ from the previous sample makes
// the following tick store the changed value and the running timestamp in
// one on-chip store (pins and time side by side in each word).
// When the target count (or the store depth) is reached, each following tick dumps
// one 7-byte frame: '@', pins, timestamp MSB first, ';'. out_tlast marks the
// ';' and out_tuser marks the ';' of the final frame. After the last frame
// the engine waits for a go byte, which loads a new target and clears time.
// Throughput: one beat per cycle while no frame is being emitted; a beat that
// dumps a frame holds the input until its seven bytes, one at a time, are loaded
// into the single output byte register. The first frame byte passes the store
// read register, then the output register. A stalled output holds its byte and
// keeps the input blocked until the frame's last byte is loaded; from then on,
// ticks that dump nothing keep flowing.
// Reset: monitor phase, last sample 0, target 255, time 0, counters 0; the
// store itself is not cleared, only written entries are ever read back.
module transition_capture_dump_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] port_pins, [15:8] go_value
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [7:0] tx_byte
  output logic             out_tlast,  // frame_end
  output logic             out_tuser   // [0] dump_done
);

  import tcd_pkg::*;

  ctl_t                  state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [7:0]            last_pins_r, last_pins_nxt;
  logic [CIDX_W-1:0]     cap_idx_r, cap_idx_nxt;
  logic [CIDX_W-1:0]     dump_idx_r, dump_idx_nxt;
  logic [7:0]            target_r, target_nxt;
  logic [TIME_BITS-1:0]  tick_r, tick_nxt;
  logic                  last_frame_r, last_frame_nxt;
  logic [2:0]            pos_r, pos_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_data_r;
  logic                  out_last_r;
  logic                  out_done_r;

  logic                  accept;
  logic [7:0]            pins;
  logic [7:0]            go_val;
  logic [CNT_W-1:0]      cap_next_w;
  logic [CNT_W-1:0]      dump_cnt;
  logic [CNT_W-1:0]      dump_next_w;
  logic [CIDX_W-1:0]     cap_inc;
  logic [CIDX_W-1:0]     dump_inc;
  logic                  out_free;

  logic                  wr_en;
  logic [ENTRY_W-1:0]    wr_data;
  logic                  rd_en;
  logic [ENTRY_W-1:0]    rd_data;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign pins      = in_tdata[7:0];
  assign go_val    = in_tdata[15:8];
  assign out_free  = !out_valid_r || out_tready;

  assign cap_inc     = cap_idx_r + 1'b1;
  assign dump_inc    = dump_idx_r + 1'b1;
  assign cap_next_w  = CNT_W'(cap_inc);
  assign dump_next_w = CNT_W'(dump_inc);
  assign dump_cnt    = (CNT_W'(target_r) < CNT_W'(CAPTURE_DEPTH)) ?
                       CNT_W'(target_r) : CNT_W'(CAPTURE_DEPTH);

  assign wr_data = {last_pins_r, tick_r};

  // Capture store: pins and timestamp per entry
  tcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPTURE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cap_idx_r[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (dump_idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Phase update on each accepted beat
  always_comb begin
    phase_nxt      = phase_r;
    last_pins_nxt  = last_pins_r;
    cap_idx_nxt    = cap_idx_r;
    dump_idx_nxt   = dump_idx_r;
    target_nxt     = target_r;
    tick_nxt       = tick_r;
    last_frame_nxt = last_frame_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    if (accept) begin
      if (in_tuser == KIND_GO) begin
        if (phase_r == PH_WAITING) begin
          target_nxt = go_val;
          tick_nxt   = '0;
          phase_nxt  = PH_MONITOR;
        end
      end else begin
        tick_nxt = tick_r + 1'b1;
        case (phase_r)
          PH_MONITOR: begin
            phase_nxt     = (pins != last_pins_r) ? PH_SAMPLING : PH_MONITOR;
            last_pins_nxt = pins;
          end
          PH_SAMPLING: begin
            // cap_idx_r never exceeds the depth, so a store is always possible
            wr_en       = 1'b1;
            cap_idx_nxt = cap_inc;
            phase_nxt   = (cap_next_w >= CNT_W'(target_r) ||
                           cap_next_w >= CNT_W'(CAPTURE_DEPTH)) ? PH_SENDING : PH_MONITOR;
          end
          PH_SENDING: begin
            if (CNT_W'(dump_idx_r) < dump_cnt) begin
              rd_en          = 1'b1;
              last_frame_nxt = (dump_next_w >= dump_cnt);
              dump_idx_nxt   = dump_inc;
              if (dump_next_w >= dump_cnt) begin
                phase_nxt    = PH_WAITING;
                cap_idx_nxt  = '0;
                dump_idx_nxt = '0;
              end
            end else begin
              phase_nxt    = PH_WAITING;
              cap_idx_nxt  = '0;
              dump_idx_nxt = '0;
            end
          end
          PH_WAITING: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Frame byte sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (rd_en) begin
          state_nxt = ST_EMIT;
          pos_nxt   = BP_HEAD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + 1'b1;
          if (pos_r == BP_TAIL) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_MONITOR;
      last_pins_r  <= '0;
      cap_idx_r    <= '0;
      dump_idx_r   <= '0;
      target_r     <= TARGET_RST;
      tick_r       <= '0;
      last_frame_r <= 1'b0;
      pos_r        <= BP_HEAD;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      last_pins_r  <= last_pins_nxt;
      cap_idx_r    <= cap_idx_nxt;
      dump_idx_r   <= dump_idx_nxt;
      target_r     <= target_nxt;
      tick_r       <= tick_nxt;
      last_frame_r <= last_frame_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Output byte register: load the next frame byte when free
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= frame_byte(pos_r, rd_data);
      out_last_r <= (pos_r == BP_TAIL);
      out_done_r <= (pos_r == BP_TAIL) && last_frame_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule
`default_nettype wire
